FILE: rtl/core/slat_pkg.sv
// Shared constants for the set-associative LRU TLB.
package slat_pkg;

  localparam int unsigned PageShiftW = 5;
  localparam int unsigned MissW      = 32;

  localparam logic [PageShiftW-1:0] PAGE_SHIFT_RESET = 5'd12;
  localparam logic [MissW-1:0]      MISS_MAX         = 32'hFFFF_FFFF;

  localparam logic KIND_TRANSLATE = 1'b0;
  localparam logic KIND_FLUSH     = 1'b1;

endpackage

FILE: rtl/core/slat_ram.sv
// One-write one-read row memory with registered read and write-to-read bypass.
module slat_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  parameter int unsigned AddrW = 6
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: rtl/core/slat_lookup.sv
// Tag compare, victim choice and LRU order update for one set.
module slat_lookup #(
  parameter int unsigned WAY_COUNT    = 4,
  parameter int unsigned ADDRESS_BITS = 48,
  parameter int unsigned WayW         = 2
) (
  input  logic [WAY_COUNT-1:0]                   valid_row_i,
  input  logic [WAY_COUNT-1:0][ADDRESS_BITS-1:0] tag_row_i,
  input  logic [WAY_COUNT-1:0][WayW-1:0]         order_row_i,
  input  logic [ADDRESS_BITS-1:0]                page_i,
  output logic                                   hit_o,
  output logic [WAY_COUNT-1:0]                   valid_row_o,
  output logic [WAY_COUNT-1:0][ADDRESS_BITS-1:0] tag_row_o,
  output logic [WAY_COUNT-1:0][WayW-1:0]         order_row_o
);

  logic                          any_valid;
  logic [WAY_COUNT-1:0][WayW-1:0] ord;
  logic [WAY_COUNT-1:0]          way_hit;
  logic [WayW-1:0]               hit_way;
  logic                          free_found;
  logic [WayW-1:0]               free_way;
  logic [WayW-1:0]               target;
  logic [WayW-1:0]               tpos;

  always_comb begin
    any_valid = |valid_row_i;
    // a set with no valid way holds the reset order
    for (int p = 0; p < WAY_COUNT; p++) begin
      ord[p] = any_valid ? order_row_i[p] : WayW'(p);
    end

    for (int w = 0; w < WAY_COUNT; w++) begin
      way_hit[w] = valid_row_i[w] && (tag_row_i[w] == page_i);
    end
    hit_o = |way_hit;

    hit_way  = '0;
    free_way = '0;
    for (int w = WAY_COUNT - 1; w >= 0; w--) begin
      if (way_hit[w]) begin
        hit_way = WayW'(w);
      end
      if (!valid_row_i[w]) begin
        free_way = WayW'(w);
      end
    end
    free_found = ~&valid_row_i;

    if (hit_o) begin
      target = hit_way;
    end else if (free_found) begin
      target = free_way;
    end else begin
      target = ord[WAY_COUNT-1];
    end

    tpos = '0;
    for (int p = 0; p < WAY_COUNT; p++) begin
      if (ord[p] == target) begin
        tpos = WayW'(p);
      end
    end

    order_row_o[0] = target;
    for (int p = 1; p < WAY_COUNT; p++) begin
      order_row_o[p] = (WayW'(p) <= tpos) ? ord[p-1] : ord[p];
    end

    tag_row_o = tag_row_i;
    if (!hit_o) begin
      tag_row_o[target] = page_i;
    end
    valid_row_o         = valid_row_i;
    valid_row_o[target] = 1'b1;
  end

endmodule

FILE: rtl/core/set_assoc_lru_tlb.sv
// Set-associative TLB with true LRU replacement, top level.
// Takes one word per cycle unless the input stalls. The result word passes from
// the input stage into the output register, which holds it until it is taken: the
// tag/order RAM read registers together with the input word, then compare and
// update run into the output register. A stalled output holds one result and one
// word in the input stage; with both full the input stalls. Tags and LRU order live
// in one-row-per-set RAMs read and written once a cycle, with a bypass for
// back-to-back words to the same set. SET_COUNT must be a power of two. No clearing
// pass: per-way valid bits are flops and a flush clears all of them together.
module set_assoc_lru_tlb
  import slat_pkg::*;
#(
  parameter int unsigned SET_COUNT    = 64,
  parameter int unsigned WAY_COUNT    = 4,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [PageShiftW-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [ADDRESS_BITS-1:0] byte_address_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    hit_o,
  output logic [MissW-1:0]        miss_total_o
);

  localparam int unsigned SetW  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned WayW  = (WAY_COUNT > 1) ? $clog2(WAY_COUNT) : 1;
  localparam int unsigned TagRowW = WAY_COUNT * ADDRESS_BITS;
  localparam int unsigned OrdRowW = WAY_COUNT * WayW;

  logic [PageShiftW-1:0]   page_shift_q;
  logic                    in_accept;
  logic [ADDRESS_BITS-1:0] in_page;
  logic [SetW-1:0]         in_set;

  logic                    s1_valid_q;
  logic                    s1_kind_q;
  logic [ADDRESS_BITS-1:0] s1_page_q;
  logic [SetW-1:0]         s1_set_q;
  logic                    s1_go;
  logic                    s1_write;

  logic [SET_COUNT-1:0][WAY_COUNT-1:0]    valid_q;
  logic [WAY_COUNT-1:0][ADDRESS_BITS-1:0] rd_tag_row;
  logic [WAY_COUNT-1:0][WayW-1:0]         rd_ord_row;
  logic                                   lk_hit;
  logic [WAY_COUNT-1:0]                   lk_valid_row;
  logic [WAY_COUNT-1:0][ADDRESS_BITS-1:0] lk_tag_row;
  logic [WAY_COUNT-1:0][WayW-1:0]         lk_ord_row;

  logic [MissW-1:0] miss_q;
  logic [MissW-1:0] miss_d;
  logic             out_valid_q;
  logic             hit_q;
  logic [MissW-1:0] total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_shift_q <= PAGE_SHIFT_RESET;
    end else if (cfg_we_i) begin
      page_shift_q <= cfg_wdata_i;
    end
  end

  assign in_page   = byte_address_i >> page_shift_q;
  assign in_set    = SetW'(in_page & ADDRESS_BITS'(SET_COUNT - 1));
  assign s1_go     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_go;
  assign in_accept = in_valid_i && !in_stall_o;
  assign s1_write  = s1_go && (s1_kind_q == KIND_TRANSLATE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_kind_q <= kind_i;
      s1_page_q <= in_page;
      s1_set_q  <= in_set;
    end
  end

  slat_ram #(
    .Depth (SET_COUNT),
    .Width (TagRowW),
    .AddrW (SetW)
  ) u_tag_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_write),
    .wr_addr_i (s1_set_q),
    .wr_data_i (lk_tag_row),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_set),
    .rd_data_o (rd_tag_row)
  );

  slat_ram #(
    .Depth (SET_COUNT),
    .Width (OrdRowW),
    .AddrW (SetW)
  ) u_ord_ram (
    .clk_i     (clk_i),
    .wr_en_i   (s1_write),
    .wr_addr_i (s1_set_q),
    .wr_data_i (lk_ord_row),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_set),
    .rd_data_o (rd_ord_row)
  );

  slat_lookup #(
    .WAY_COUNT    (WAY_COUNT),
    .ADDRESS_BITS (ADDRESS_BITS),
    .WayW         (WayW)
  ) u_lookup (
    .valid_row_i (valid_q[s1_set_q]),
    .tag_row_i   (rd_tag_row),
    .order_row_i (rd_ord_row),
    .page_i      (s1_page_q),
    .hit_o       (lk_hit),
    .valid_row_o (lk_valid_row),
    .tag_row_o   (lk_tag_row),
    .order_row_o (lk_ord_row)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (s1_go && (s1_kind_q == KIND_FLUSH)) begin
      valid_q <= '0;
    end else if (s1_write) begin
      valid_q[s1_set_q] <= lk_valid_row;
    end
  end

  always_comb begin
    if (s1_kind_q == KIND_FLUSH) begin
      miss_d = '0;
    end else if (!lk_hit && (miss_q != MISS_MAX)) begin
      miss_d = miss_q + MissW'(1);
    end else begin
      miss_d = miss_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else if (s1_go) begin
      miss_q      <= miss_d;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      hit_q   <= (s1_kind_q == KIND_TRANSLATE) && lk_hit;
      total_q <= miss_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign miss_total_o = total_q;

  a_flush_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_go && (s1_kind_q == KIND_FLUSH) |=> out_valid_o && !hit_o && (miss_total_o == '0))
    else $error("flush word did not return a cleared result");

  a_hit_keeps_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_write && lk_hit |=> miss_q == $past(miss_q))
    else $error("miss count moved on a hit");

  a_miss_never_drops: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_write |=> miss_q >= $past(miss_q))
    else $error("miss count dropped without a flush");

  a_stall_has_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with a free pipeline");

endmodule

FILE: tb/tlb_checker.sv
// Checker for the set-associative LRU TLB: predicts each lookup and compares results.
`timescale 1ns / 100ps

module tlb_checker
  import slat_pkg::*;
#(
  parameter int unsigned SET_COUNT    = 64,
  parameter int unsigned WAY_COUNT    = 4,
  parameter int unsigned ADDRESS_BITS = 48
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [PageShiftW-1:0]   cfg_wdata_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    kind_i,
  input  logic [ADDRESS_BITS-1:0] byte_address_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic                    hit_i,
  input  logic [MissW-1:0]        miss_total_i,
  output int                      fail_count_o,
  output int                      pending_o
);

  typedef struct packed {
    logic             hit;
    logic [MissW-1:0] miss_total;
  } lookup_word_t;

  logic [ADDRESS_BITS-1:0] page_tag   [SET_COUNT][WAY_COUNT];
  bit                      way_valid  [SET_COUNT][WAY_COUNT];
  int unsigned             lru_rank   [SET_COUNT][WAY_COUNT];
  logic [MissW-1:0]        miss_tally;
  logic [PageShiftW-1:0]   page_shift;
  lookup_word_t            awaited_lookups [$];

  task automatic make_most_recent(input int unsigned set_idx, input int unsigned pos);
    int unsigned way;
    way = lru_rank[set_idx][pos];
    for (int p = int'(pos); p > 0; p--) lru_rank[set_idx][p] = lru_rank[set_idx][p-1];
    lru_rank[set_idx][0] = way;
  endtask

  task automatic clear_tlb();
    for (int s = 0; s < SET_COUNT; s++) begin
      for (int w = 0; w < WAY_COUNT; w++) begin
        way_valid[s][w] = 1'b0;
        lru_rank[s][w]  = unsigned'(w);
      end
    end
  endtask

  task automatic translate_word(input logic kind, input logic [ADDRESS_BITS-1:0] addr,
                                output lookup_word_t res);
    logic [ADDRESS_BITS-1:0] page;
    int unsigned             set_idx;
    int                      hit_pos;
    int                      victim;
    int                      victim_pos;
    hit_pos    = -1;
    victim     = -1;
    victim_pos = -1;
    if (kind == KIND_FLUSH) begin
      clear_tlb();
      miss_tally     = '0;
      res.hit        = 1'b0;
      res.miss_total = '0;
    end else begin
      page    = addr >> page_shift;
      set_idx = 32'(page % SET_COUNT);
      for (int pos = 0; pos < WAY_COUNT; pos++) begin
        if (hit_pos < 0 && way_valid[set_idx][lru_rank[set_idx][pos]] &&
            page_tag[set_idx][lru_rank[set_idx][pos]] == page) begin
          hit_pos = pos;
        end
      end
      if (hit_pos >= 0) begin
        make_most_recent(set_idx, unsigned'(hit_pos));
      end else begin
        if (miss_tally != MISS_MAX) miss_tally++;
        // lowest free way first, else the least recent one
        for (int w = 0; w < WAY_COUNT; w++) begin
          if (victim < 0 && !way_valid[set_idx][w]) victim = w;
        end
        if (victim < 0) victim = int'(lru_rank[set_idx][WAY_COUNT-1]);
        page_tag[set_idx][victim]  = page;
        way_valid[set_idx][victim] = 1'b1;
        for (int pos = 0; pos < WAY_COUNT; pos++) begin
          if (lru_rank[set_idx][pos] == unsigned'(victim)) victim_pos = pos;
        end
        make_most_recent(set_idx, unsigned'(victim_pos));
      end
      res.hit        = (hit_pos >= 0);
      res.miss_total = miss_tally;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_word_t res;
    if (!rst_ni) begin
      clear_tlb();
      miss_tally = '0;
      page_shift = PAGE_SHIFT_RESET;
      awaited_lookups.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (awaited_lookups.size() == 0) begin
          $display("%0t: unexpected word, expected none, got hit %0b miss_total %0d",
                   $time, hit_i, miss_total_i);
          fail_count_o++;
        end else begin
          res = awaited_lookups.pop_front();
          if (res.hit !== hit_i) begin
            $display("%0t: hit expected %0b, got %0b", $time, res.hit, hit_i);
            fail_count_o++;
          end
          if (res.miss_total !== miss_total_i) begin
            $display("%0t: miss_total expected %0d, got %0d",
                     $time, res.miss_total, miss_total_i);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        translate_word(kind_i, byte_address_i, res);
        awaited_lookups.push_back(res);
      end
      if (cfg_we_i) page_shift = cfg_wdata_i;
    end
    pending_o = awaited_lookups.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the set-associative LRU TLB: stimulus, handshake idling and verdict.
`timescale 1ns / 100ps

module tb
  import slat_pkg::*;
();

  localparam int unsigned AddrW    = 48;
  localparam int unsigned CycleCap = 400000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [PageShiftW-1:0] cfg_wdata_i;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic                  kind_i;
  logic [AddrW-1:0]      byte_address_i;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic                  hit_o;
  logic [MissW-1:0]      miss_total_o;

  int          fail_count;
  int          pending;
  int unsigned send_idle_pct;
  int unsigned stall_pct;
  int unsigned hold_req_count = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned cycle_count = 0;

  always #1 clk_i = ~clk_i;

  set_assoc_lru_tlb i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .byte_address_i (byte_address_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_o          (hit_o),
    .miss_total_o   (miss_total_o)
  );

  tlb_checker i_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_i     (in_stall_o),
    .kind_i         (kind_i),
    .byte_address_i (byte_address_i),
    .out_valid_i    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .hit_i          (hit_o),
    .miss_total_i   (miss_total_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending)
  );

  // receiver: random stall, or a long counted hold-off on request
  always @(posedge clk_i) begin
    if (hold_req_count != hold_seen) begin
      hold_seen = hold_req_count;
      hold_left = 300;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleCap) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_word(input logic kind, input logic [AddrW-1:0] addr);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    kind_i         <= kind;
    byte_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_page_shift(input logic [PageShiftW-1:0] value);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [PageShiftW-1:0] shifts [8];
    logic [AddrW-1:0]      tag_pool [6];
    logic [63:0]           wide;
    int unsigned           hot_set;
    int unsigned           set_idx;
    int unsigned           pick;

    shifts         = '{5'd12, 5'd0, 5'd31, 5'd21, 5'd30, 5'd13, 5'd26, 5'd17};
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    kind_i         = KIND_TRANSLATE;
    byte_address_i = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset page size, extremes, eviction, flush
    send_word(KIND_TRANSLATE, '0);
    send_word(KIND_TRANSLATE, '0);
    send_word(KIND_TRANSLATE, 48'hFFF);
    send_word(KIND_TRANSLATE, '1);
    send_word(KIND_TRANSLATE, '1);
    for (int t = 1; t <= 5; t++) send_word(KIND_TRANSLATE, AddrW'(t * 64 + 5) << 12);
    drain();
    send_word(KIND_TRANSLATE, AddrW'(1 * 64 + 5) << 12);
    send_word(KIND_TRANSLATE, (AddrW'(5 * 64 + 5) << 12) | 48'hABC);
    send_word(KIND_FLUSH, '1);
    send_word(KIND_TRANSLATE, '0);
    send_word(KIND_TRANSLATE, 48'h8000_0000_0000);
    send_word(KIND_FLUSH, '0);
    send_word(KIND_TRANSLATE, 48'h8000_0000_0000);

    for (int phase = 0; phase < 8; phase++) begin
      write_page_shift(shifts[phase]);
      case (phase % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 76; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 76; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      foreach (tag_pool[i]) tag_pool[i] = AddrW'({$urandom, $urandom});
      hot_set = $urandom_range(60);
      for (int n = 0; n < 240; n++) begin
        if (phase == 4 && n == 40) hold_req_count++;
        if (phase == 5 && n == 120) drain();
        pick = $urandom_range(99);
        if (pick < 2) begin
          send_word(KIND_FLUSH, AddrW'({$urandom, $urandom}));
        end else if (pick < 17) begin
          send_word(KIND_TRANSLATE, AddrW'({$urandom, $urandom}));
        end else begin
          set_idx = ($urandom_range(3) != 0) ? hot_set + $urandom_range(3) : $urandom_range(63);
          wide = (64'({tag_pool[$urandom_range(5)], 6'(set_idx)}) << shifts[phase]) |
                 ({$urandom, $urandom} & ((64'd1 << shifts[phase]) - 64'd1));
          send_word(KIND_TRANSLATE, wide[AddrW-1:0]);
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: set_assoc_lru_tlb.f
rtl/core/slat_pkg.sv
rtl/core/slat_ram.sv
rtl/core/slat_lookup.sv
rtl/core/set_assoc_lru_tlb.sv
tb/tlb_checker.sv
tb/tb.sv
